FILE: rtl/point_segment_distance_3d_core_assert.svh
// Assertion macros for the checker file of the point/segment distance core.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef POINT_SEGMENT_DISTANCE_3D_CORE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_3D_CORE_ASSERT_SVH

// same-cycle implication
`define PSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psd assertion failed");

// next-cycle implication
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psd assertion failed");

`endif

FILE: rtl/psd_pkg.sv
// Shared constants and types for the point/segment distance core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int DIST_W = 25;
  localparam int KIND_W = 2;

  // default-configuration widths for the divider and root units
  localparam int DEN_W_DEF  = 2 * COORD_BITS_DEF + 2;
  localparam int QUO_W_DEF  = DEN_W_DEF + 2 * FRAC_BITS_DEF;
  localparam int NUM_W_DEF  = 2 * (2 * COORD_BITS_DEF + 3) + 2 + 2 * FRAC_BITS_DEF;
  localparam int ROOT_W_DEF = COORD_BITS_DEF + 2 + FRAC_BITS_DEF;

  typedef enum logic [KIND_W-1:0] {
    KIND_PERP  = 2'd0,
    KIND_END   = 2'd1,
    KIND_DEGEN = 2'd2
  } case_kind_e;

endpackage

`default_nettype wire

FILE: rtl/psd_if.sv
// Request and result channel interfaces of the point/segment distance core.
// Depends on psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface psd_in_if #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic signed [COORD_BITS-1:0] ax, ay, az;
  logic signed [COORD_BITS-1:0] bx, by_coord, bz;

  modport source (output valid, px, py, pz, ax, ay, az, bx, by_coord, bz, input ready);
  modport sink   (input valid, px, py, pz, ax, ay, az, bx, by_coord, bz, output ready);
endinterface

interface psd_out_if ();
  import psd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [KIND_W-1:0] case_kind;

  modport source (output valid, distance, case_kind, input ready);
  modport sink   (input valid, distance, case_kind, output ready);
endinterface

`default_nettype wire

FILE: rtl/psd_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; defaults from psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_div_pipe #(
  parameter int NUM_W  = psd_pkg::NUM_W_DEF,
  parameter int DEN_W  = psd_pkg::DEN_W_DEF,
  parameter int QUO_W  = psd_pkg::QUO_W_DEF,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  low_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic              vld_q  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W-1:0]  rem_in, den_in, rem_d;
    logic [QUO_W-1:0]  low_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [DEN_W:0]    x, diff;
    logic              ge;

    if (k == 0) begin : g_first
      // top part of the numerator is known to be below the divisor
      assign rem_in  = num_i[QUO_W+DEN_W-1:QUO_W];
      assign low_in  = num_i[QUO_W-1:0];
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign x     = {rem_in, low_in[QUO_W-1]};
    assign diff  = x - {1'b0, den_in};
    assign ge    = (x >= {1'b0, den_in});
    assign rem_d = ge ? diff[DEN_W-1:0] : x[DEN_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= {low_in[QUO_W-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = low_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/psd_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
// Standalone; defaults from psd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psd_sqrt_pipe #(
  parameter int RAD_W  = psd_pkg::QUO_W_DEF,
  parameter int ROOT_W = psd_pkg::ROOT_W_DEF,
  parameter int SIDE_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int SQ_W = 2 * ROOT_W;

  logic [ROOT_W-1:0] r_q    [ROOT_W];
  logic [SQ_W-1:0]   sq_q   [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int B = ROOT_W - 1 - k;
    logic [ROOT_W-1:0] r_in;
    logic [SQ_W-1:0]   sq_in, trial;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in, ok;

    if (k == 0) begin : g_first
      assign r_in    = '0;
      assign sq_in   = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign r_in    = r_q[k-1];
      assign sq_in   = sq_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (r + 2^B)^2 from the running square
    assign trial = sq_in + (SQ_W'(r_in) << (B + 1)) + (SQ_W'(1) << (2 * B));
    assign ok    = (trial <= SQ_W'(rad_in));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ok ? (r_in | (ROOT_W'(1) << B)) : r_in;
        sq_q[k]   <= ok ? trial : sq_in;
        rad_q[k]  <= rad_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = r_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/point_segment_distance_3d_core.sv
// Top level of the 3D point to segment distance core.
// Depends on psd_pkg, psd_if, psd_div_pipe, psd_sqrt_pipe.
//
//   channel  port   dir  payload
//   request  req_i  in   px py pz ax ay az bx by_coord bz (signed COORD_BITS)
//   result   rsp_o  out  distance (25b, Q17.8), case_kind (2b)
//
// One request enters per cycle while no result is stalled at the output. A request
// passes the front stages (differences, products, sums, case decision, scaled
// numerator), the one-bit-per-stage divider and root pipelines and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// A result held at the output freezes every stage at once, so nothing is
// dropped or repeated; req_i.ready is low only while rsp_o holds a result.
`timescale 1ns / 1ps
`default_nettype none

module point_segment_distance_3d_core #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = psd_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  psd_in_if.sink      req_i,
  psd_out_if.source   rsp_o
);
  import psd_pkg::*;

  localparam int DW    = COORD_BITS + 1;       // coordinate difference
  localparam int PW    = 2 * DW;               // one product
  localparam int SW3   = PW + 2;               // dot product
  localparam int CW    = PW + 1;               // cross component
  localparam int NUMB  = 2 * CW + 2;           // |AP x AB|^2
  localparam int NW    = NUMB + 2 * FRAC_BITS; // scaled numerator
  localparam int DENW  = 2 * COORD_BITS + 2;   // squared lengths
  localparam int QW    = DENW + 2 * FRAC_BITS; // radicand
  localparam int RW    = COORD_BITS + 2 + FRAC_BITS;
  localparam int SIDEW = KIND_W + QW;

  // whole pipe advances unless the output register is full and stalled
  logic adv;
  assign adv         = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = adv;

  // ---- stage 1: differences
  logic signed [DW-1:0] ap_d [3], ab_d [3], bp_d [3];
  logic signed [DW-1:0] ap_q [3], ab_q [3], bp_q [3];
  logic                 v1_q;

  always_comb begin
    ap_d[0] = DW'(req_i.px) - DW'(req_i.ax);
    ap_d[1] = DW'(req_i.py) - DW'(req_i.ay);
    ap_d[2] = DW'(req_i.pz) - DW'(req_i.az);
    ab_d[0] = DW'(req_i.bx) - DW'(req_i.ax);
    ab_d[1] = DW'(req_i.by_coord) - DW'(req_i.ay);
    ab_d[2] = DW'(req_i.bz) - DW'(req_i.az);
    bp_d[0] = DW'(req_i.px) - DW'(req_i.bx);
    bp_d[1] = DW'(req_i.py) - DW'(req_i.by_coord);
    bp_d[2] = DW'(req_i.pz) - DW'(req_i.bz);
  end

  // ---- stage 2: all products in parallel
  logic signed [PW-1:0] apab_q [3], bpab_q [3], apsq_q [3], bpsq_q [3], absq_q [3];
  logic signed [PW-1:0] xa_q [3], xb_q [3];
  logic                 v2_q;

  // ---- stage 3: sums
  logic signed [SW3-1:0] d1_q, e_q;
  logic [DENW-1:0]       sa_q, sb_q, dab_q;
  logic signed [CW-1:0]  c_q [3];
  logic                  v3_q;

  // ---- stage 4: case decision, squared cross components
  logic [CW-1:0]     cmag [3];
  logic [2*CW-1:0]   csq_q [3];
  logic [DENW-1:0]   den4_q;
  logic [KIND_W-1:0] kind4_d, kind4_q;
  logic [DENW-1:0]   end_sel;
  logic [QW-1:0]     alt4_q;
  logic              v4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_q[i][CW-1] ? (~c_q[i] + CW'(1)) : c_q[i];
    end
    if (dab_q == '0) begin
      kind4_d = KIND_DEGEN;
      end_sel = sa_q;
    end else begin
      kind4_d = (d1_q[SW3-1] || (!e_q[SW3-1] && e_q != '0)) ? KIND_END : KIND_PERP;
      end_sel = (sa_q < sb_q) ? sa_q : sb_q;
    end
  end

  // ---- stage 5: scaled numerator
  logic [NW-1:0]     num5_q;
  logic [DENW-1:0]   den5_q;
  logic [KIND_W-1:0] kind5_q;
  logic [QW-1:0]     alt5_q;
  logic              v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ap_q <= ap_d;
      ab_q <= ab_d;
      bp_q <= bp_d;

      for (int i = 0; i < 3; i++) begin
        apab_q[i] <= ap_q[i] * ab_q[i];
        bpab_q[i] <= bp_q[i] * ab_q[i];
        apsq_q[i] <= ap_q[i] * ap_q[i];
        bpsq_q[i] <= bp_q[i] * bp_q[i];
        absq_q[i] <= ab_q[i] * ab_q[i];
      end
      // cross terms: c = xa - xb
      xa_q[0] <= ap_q[1] * ab_q[2];
      xb_q[0] <= ap_q[2] * ab_q[1];
      xa_q[1] <= ap_q[2] * ab_q[0];
      xb_q[1] <= ap_q[0] * ab_q[2];
      xa_q[2] <= ap_q[0] * ab_q[1];
      xb_q[2] <= ap_q[1] * ab_q[0];

      d1_q  <= SW3'(apab_q[0]) + SW3'(apab_q[1]) + SW3'(apab_q[2]);
      e_q   <= SW3'(bpab_q[0]) + SW3'(bpab_q[1]) + SW3'(bpab_q[2]);
      sa_q  <= $unsigned(apsq_q[0]) + $unsigned(apsq_q[1]) + $unsigned(apsq_q[2]);
      sb_q  <= $unsigned(bpsq_q[0]) + $unsigned(bpsq_q[1]) + $unsigned(bpsq_q[2]);
      dab_q <= $unsigned(absq_q[0]) + $unsigned(absq_q[1]) + $unsigned(absq_q[2]);
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= CW'(xa_q[i]) - CW'(xb_q[i]);
      end

      for (int i = 0; i < 3; i++) begin
        csq_q[i] <= cmag[i] * cmag[i];
      end
      den4_q  <= dab_q;
      kind4_q <= kind4_d;
      alt4_q  <= QW'(end_sel) << (2 * FRAC_BITS);

      num5_q  <= NW'(NUMB'(csq_q[0]) + NUMB'(csq_q[1]) + NUMB'(csq_q[2])) << (2 * FRAC_BITS);
      den5_q  <= den4_q;
      kind5_q <= kind4_q;
      alt5_q  <= alt4_q;
    end
  end

  // ---- divider: |AP x AB|^2 * 2^2F / |AB|^2
  logic              div_v;
  logic [QW-1:0]     div_quo;
  logic [SIDEW-1:0]  div_side;
  logic [KIND_W-1:0] div_kind;
  logic [QW-1:0]     div_alt;

  psd_div_pipe #(
    .NUM_W  (NW),
    .DEN_W  (DENW),
    .QUO_W  (QW),
    .SIDE_W (SIDEW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .num_i   (num5_q),
    .den_i   (den5_q),
    .side_i  ({kind5_q, alt5_q}),
    .valid_o (div_v),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  assign div_kind = div_side[SIDEW-1:QW];
  assign div_alt  = div_side[QW-1:0];

  // ---- root of the chosen radicand
  logic              sq_v;
  logic [RW-1:0]     sq_root;
  logic [KIND_W-1:0] sq_kind;
  logic [QW-1:0]     rad;

  assign rad = (div_kind == KIND_PERP) ? div_quo : div_alt;

  psd_sqrt_pipe #(
    .RAD_W  (QW),
    .ROOT_W (RW),
    .SIDE_W (KIND_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (div_v),
    .rad_i   (rad),
    .side_i  (div_kind),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_kind)
  );

  // ---- output register with saturation to the 25-bit field
  logic [RW+DIST_W-1:0] root_ext;
  logic                 sat;
  logic                 out_v_q;
  logic [DIST_W-1:0]    out_dist_q;
  logic [KIND_W-1:0]    out_kind_q;

  assign root_ext = (RW + DIST_W)'(sq_root);
  assign sat      = |root_ext[RW+DIST_W-1:DIST_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_dist_q <= sat ? '1 : root_ext[DIST_W-1:0];
      out_kind_q <= sq_kind;
    end
  end

  assign rsp_o.valid     = out_v_q;
  assign rsp_o.distance  = out_dist_q;
  assign rsp_o.case_kind = out_kind_q;

endmodule

`default_nettype wire

FILE: rtl/psd_checker.sv
// Port-level checks for the point/segment distance core, bound to the top level.
// Depends on psd_pkg and point_segment_distance_3d_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "point_segment_distance_3d_core_assert.svh"

module psd_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [psd_pkg::DIST_W-1:0] distance_i,
  input wire logic [psd_pkg::KIND_W-1:0] case_kind_i
);
  import psd_pkg::*;

  // held result stays offered
  `PSD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // held result does not change
  `PSD_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(distance_i) && $stable(case_kind_i))
  // a stalled result freezes the whole pipe, so no request may enter
  `PSD_ASSERT_IMP(a_in_blocked, out_valid_i && !out_ready_i, !in_ready_i)
  // free output always takes requests
  `PSD_ASSERT_IMP(a_in_open, !out_valid_i, in_ready_i || !in_valid_i)

endmodule

bind point_segment_distance_3d_core psd_checker u_psd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .distance_i  (rsp_o.distance),
  .case_kind_i (rsp_o.case_kind)
);

`default_nettype wire

FILE: tb/point_segment_distance_3d_core_tb.sv
// Self-checking testbench of the 3D point to segment distance core.
// Depends on psd_pkg, psd_if and point_segment_distance_3d_core.
`timescale 1ns / 1ps

module point_segment_distance_3d_core_tb;
  import psd_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 5 + (2*CB + 2 + 2*FB) + (CB + 2 + FB) + 1;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    case_kind_e        kind;
  } dist_result_t;

  typedef logic signed [CB-1:0] coord_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  psd_in_if  #(.COORD_BITS(CB)) req_if ();
  psd_out_if                    rsp_if ();

  point_segment_distance_3d_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  dist_result_t expected_q[$];
  int  n_errors   = 0;
  int  n_requests = 0;
  int  n_results  = 0;
  int  n_kind[3]  = '{0, 0, 0};
  int  idle_cycles = 0;
  bit  long_hold  = 1'b0;  // forces the receiver to stall
  bit  rx_gaps    = 1'b1;

  // Largest r with r*r*den <= num, bit by bit; widths cover the worst case.
  function automatic logic [63:0] isqrt_ratio(logic [127:0] num, logic [127:0] den);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [191:0] sq;
    r = '0;
    for (int b = CB + 2 + FB - 1; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = 192'(c) * 192'(c) * 192'(den);
      if (sq <= 192'(num)) r = c;
    end
    return r;
  endfunction

  // Predicts the distance and case for one request.
  function automatic dist_result_t predict_distance(coord_t p[3], coord_t a[3], coord_t b[3]);
    longint        ap[3], ab[3], bp[3], cr[3];
    longint        dot_a, dot_b;
    logic [63:0]   dab, sa, sb, root_val;
    logic [127:0]  num;
    dist_result_t  res;
    for (int i = 0; i < 3; i++) begin
      ap[i] = longint'(p[i]) - longint'(a[i]);
      ab[i] = longint'(b[i]) - longint'(a[i]);
      bp[i] = longint'(p[i]) - longint'(b[i]);
    end
    dab = ab[0]*ab[0] + ab[1]*ab[1] + ab[2]*ab[2];
    sa  = ap[0]*ap[0] + ap[1]*ap[1] + ap[2]*ap[2];
    sb  = bp[0]*bp[0] + bp[1]*bp[1] + bp[2]*bp[2];
    if (dab == 0) begin
      root_val = isqrt_ratio(128'(sa) << (2*FB), 128'd1);
      res.kind = KIND_DEGEN;
    end else begin
      dot_a = ap[0]*ab[0] + ap[1]*ab[1] + ap[2]*ab[2];
      dot_b = -(bp[0]*ab[0] + bp[1]*ab[1] + bp[2]*ab[2]);
      if (dot_a < 0 || dot_b < 0) begin
        root_val = isqrt_ratio(128'((sa < sb) ? sa : sb) << (2*FB), 128'd1);
        res.kind = KIND_END;
      end else begin
        cr[0] = ap[1]*ab[2] - ap[2]*ab[1];
        cr[1] = ap[2]*ab[0] - ap[0]*ab[2];
        cr[2] = ap[0]*ab[1] - ap[1]*ab[0];
        num = '0;
        for (int i = 0; i < 3; i++) begin
          num += 128'(cr[i]) * 128'(cr[i]);  // sign ignored by squaring
        end
        root_val = isqrt_ratio(num << (2*FB), 128'(dab));
        res.kind = KIND_PERP;
      end
    end
    res.distance = (root_val > 64'((1 << DIST_W) - 1)) ? DIST_W'((1 << DIST_W) - 1)
                                                        : root_val[DIST_W-1:0];
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Inputs start at zero; later they are driven at the rising edge with nonblocking assignments.
  initial begin
    req_if.valid    = 1'b0;
    req_if.px       = '0;
    req_if.py       = '0;
    req_if.pz       = '0;
    req_if.ax       = '0;
    req_if.ay       = '0;
    req_if.az       = '0;
    req_if.bx       = '0;
    req_if.by_coord = '0;
    req_if.bz       = '0;
    rsp_if.ready    = 1'b0;
  end

  // Sends one request; valid stays high when the next one follows at once.
  task automatic send_request(coord_t p[3], coord_t a[3], coord_t b[3], int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.px       <= p[0];
    req_if.py       <= p[1];
    req_if.pz       <= p[2];
    req_if.ax       <= a[0];
    req_if.ay       <= a[1];
    req_if.az       <= a[2];
    req_if.bx       <= b[0];
    req_if.by_coord <= b[1];
    req_if.bz       <= b[2];
    do @(posedge clk_i); while (!req_if.ready);
    // accepted at this edge: record the expectation
    expected_q.push_back(predict_distance(p, a, b));
    n_requests++;
  endtask

  // Receiver ready pattern, with random gaps or a forced long hold.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        rsp_if.ready <= 1'b0;
      end else if (rx_gaps && rsp_if.ready && $urandom_range(0, 3) == 0) begin
        hold = gap_len() + 1;
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  initial begin
    dist_result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result distance=%0d kind=%0d", $time,
                   rsp_if.distance, rsp_if.case_kind);
          n_errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.kind <= KIND_DEGEN) n_kind[exp_r.kind]++;
          if (rsp_if.distance !== exp_r.distance) begin
            $display("%0t: distance mismatch expected %0d actual %0d", $time,
                     exp_r.distance, rsp_if.distance);
            n_errors++;
          end
          if (rsp_if.case_kind !== exp_r.kind) begin
            $display("%0t: case_kind mismatch expected %0d actual %0d", $time,
                     exp_r.kind, rsp_if.case_kind);
            n_errors++;
          end
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either side, outside a forced long hold.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || long_hold)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_q.size());
        $display("point_segment_distance_3d_core_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic coord_t rand_coord(int span);
    if (span <= 0) return coord_t'($urandom());
    return coord_t'($urandom_range(0, 2*span) - span);
  endfunction

  // Stops offering and waits for every outstanding result.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, degenerate segments, endpoint ties and collinear points.
  task automatic test_directed();
    coord_t p[3], a[3], b[3];
    coord_t mx, mn;
    mx = coord_t'(2**(CB-1) - 1);
    mn = coord_t'(-(2**(CB-1)));
    p = '{0, 0, 0};  a = '{0, 0, 0};  b = '{0, 0, 0};  send_request(p, a, b, 0);
    p = '{mx, mx, mx}; a = '{mn, mn, mn}; b = '{mn, mn, mn}; send_request(p, a, b, 0);
    p = '{mn, mn, mn}; a = '{mx, mx, mx}; b = '{mx, mx, mx}; send_request(p, a, b, 1);
    p = '{mx, mn, mx}; a = '{mn, mx, mn}; b = '{mx, mx, mn}; send_request(p, a, b, 0);
    p = '{0, mx, 0};  a = '{mn, 0, 0};  b = '{mx, 0, 0};  send_request(p, a, b, 0);
    p = '{0, mn, mx}; a = '{mn, mn, mn}; b = '{mx, mx, mx}; send_request(p, a, b, 2);
    p = '{mx, mx, mx}; a = '{mn, mn, mn}; b = '{0, 0, 0};  send_request(p, a, b, 0);
    p = '{mn, mn, mn}; a = '{0, 0, 0};  b = '{mx, mx, mx}; send_request(p, a, b, 0);
    // tie between the two endpoints, beyond neither
    p = '{0, 10, 0};  a = '{-5, 0, 0};  b = '{5, 0, 0};  send_request(p, a, b, 0);
    // point level with an endpoint: dot test exactly zero
    p = '{5, 7, 0};   a = '{-5, 0, 0};  b = '{5, 0, 0};  send_request(p, a, b, 0);
    // point beyond B, then beyond A
    p = '{9, 3, 1};   a = '{-5, 0, 0};  b = '{5, 0, 0};  send_request(p, a, b, 0);
    p = '{-9, 3, 1};  a = '{-5, 0, 0};  b = '{5, 0, 0};  send_request(p, a, b, 3);
    // point on the segment and on its line
    p = '{2, 2, 2};   a = '{0, 0, 0};   b = '{4, 4, 4};  send_request(p, a, b, 0);
    p = '{8, 8, 8};   a = '{0, 0, 0};   b = '{4, 4, 4};  send_request(p, a, b, 0);
    // unit segment, point equal to an endpoint
    p = '{1, 0, 0};   a = '{0, 0, 0};   b = '{1, 0, 0};  send_request(p, a, b, 0);
    p = '{-1, -1, -1}; a = '{-1, -1, -1}; b = '{-1, -1, -1}; send_request(p, a, b, 0);
    p = '{mx, 0, mn}; a = '{0, mx, 0};  b = '{0, mn, 0};  send_request(p, a, b, 0);
    p = '{3, -4, 12}; a = '{0, 0, 0};   b = '{0, 0, 0};  send_request(p, a, b, 0);
    wait_drained();
  endtask

  task automatic random_request(int gap);
    coord_t p[3], a[3], b[3];
    int span, mode;
    mode = $urandom_range(0, 9);
    span = (mode < 3) ? 0 : (mode < 6) ? 300 : (mode < 8) ? 20 : 3;
    for (int i = 0; i < 3; i++) begin
      p[i] = rand_coord(span);
      a[i] = rand_coord(span);
      b[i] = ($urandom_range(0, 19) == 0) ? a[i] : rand_coord(span);
    end
    send_request(p, a, b, gap);
  endtask

  // Random geometry with random gaps on both sides.
  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      random_request(($urandom_range(0, 4) == 0) ? 0 : gap_len());
    end
  endtask

  // Back-to-back requests, no idling on either side.
  task automatic test_streaming(int n);
    rx_gaps = 1'b0;
    for (int k = 0; k < n; k++) random_request(0);
    wait_drained();
    rx_gaps = 1'b1;
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure(int n);
    long_hold = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk_i);
        long_hold = 1'b0;
      end
      for (int k = 0; k < n; k++) random_request(0);
    join
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(400);
    test_streaming(200);
    test_backpressure(200);
    test_random(300);

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d results: %0d perpendicular, %0d endpoint,",
             n_requests, n_results, n_kind[0], n_kind[1]);
    $display("%0d degenerate; random gaps, streaming and a long result stall.", n_kind[2]);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("point_segment_distance_3d_core_tb: PASS");
    end else begin
      $display("%0d errors, %0d results missing", n_errors, expected_q.size());
      $display("point_segment_distance_3d_core_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/psd_pkg.sv
rtl/psd_if.sv
rtl/psd_div_pipe.sv
rtl/psd_sqrt_pipe.sv
rtl/point_segment_distance_3d_core.sv
rtl/psd_checker.sv
tb/point_segment_distance_3d_core_tb.sv
